// ===== rtl/core/dcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_pkg: shared types and constants of the DC charge sequencer
// Register indexes, field widths, pilot and phase codes, state structs.
// ----------------------------------------------------------------------------
package dcs_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_STANDBY_TICKS    = 3'd0;
  localparam logic [2:0] CFG_INIT_TICKS       = 3'd1;
  localparam logic [2:0] CFG_WELD_TICKS       = 3'd2;
  localparam logic [2:0] CFG_PRECHARGE_TICKS  = 3'd3;
  localparam logic [2:0] CFG_SETTLE_TICKS     = 3'd4;
  localparam logic [2:0] CFG_PRECHARGE_WINDOW = 3'd5;
  localparam logic [2:0] CFG_AC_POWER_CODE    = 3'd6;
  localparam logic [2:0] CFG_DC_POWER_CODE    = 3'd7;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  // Reset values of the configuration registers
  localparam logic [7:0]  RST_STANDBY_TICKS    = 8'd10;
  localparam logic [7:0]  RST_INIT_TICKS       = 8'd40;
  localparam logic [7:0]  RST_WELD_TICKS       = 8'd10;
  localparam logic [7:0]  RST_PRECHARGE_TICKS  = 8'd20;
  localparam logic [7:0]  RST_SETTLE_TICKS     = 8'd10;
  localparam logic [9:0]  RST_PRECHARGE_WINDOW = 10'd20;
  localparam logic [11:0] RST_AC_POWER_CODE    = 12'(6500 / 25);
  localparam logic [11:0] RST_DC_POWER_CODE    = 12'(49000 / 25);

  // Word widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // Pilot codes
  localparam logic [2:0] PILOT_PWM_A = 3'd1;
  localparam logic [2:0] PILOT_PWM_B = 3'd2;
  localparam logic [2:0] PILOT_DC_A  = 3'd4;
  localparam logic [2:0] PILOT_DC_B  = 3'd5;

  // Charge mode codes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_AC   = 2'd1;
  localparam logic [1:0] MODE_DC   = 2'd2;

  // Phase codes sent to the station
  localparam logic [3:0] PHASE_STANDBY   = 4'h0;
  localparam logic [3:0] PHASE_INIT      = 4'h1;
  localparam logic [3:0] PHASE_PRECHARGE = 4'h2;
  localparam logic [3:0] PHASE_TRANSFER  = 4'h3;
  localparam logic [3:0] PHASE_WELD      = 4'h9;

  // Contactor commands
  localparam logic [3:0] CONTACTOR_OPEN  = 4'h0;
  localparam logic [3:0] CONTACTOR_CLOSE = 4'h2;

  // End of charge time codes
  localparam logic [7:0] END_TIME_NONE = 8'h00;
  localparam logic [7:0] END_TIME_SET  = 8'hFE;

  // Status codes
  localparam logic [1:0] STATUS_NOT_READY = 2'd0;
  localparam logic [1:0] STATUS_READY_DC  = 2'd1;
  localparam logic [1:0] STATUS_READY_AC  = 2'd2;

  typedef struct packed {
    logic [7:0]  standby_ticks;
    logic [7:0]  init_ticks;
    logic [7:0]  weld_ticks;
    logic [7:0]  precharge_ticks;
    logic [7:0]  settle_ticks;
    logic [9:0]  precharge_window;
    logic [11:0] ac_power_code;
    logic [11:0] dc_power_code;
  } dcs_cfg_t;

  typedef struct packed {
    logic              run_mode;
    logic              plug_present;
    logic              charge_disabled;
    logic [2:0]        pilot_mode;
    logic [8:0]        contactor_volts;
    logic [9:0]        battery_volts;
    logic signed [9:0] current_request;
  } dcs_in_t;

  typedef struct packed {
    logic [2:0]        seq_state;
    logic [7:0]        dwell_count;
    logic [3:0]        phase;
    logic [3:0]        contactor;
    logic signed [9:0] current;
    logic [7:0]        end_time;
    logic [1:0]        status;
    logic              request;
    logic              ready;
    logic [11:0]       power;
  } dcs_state_t;

endpackage

// ===== rtl/core/dcs_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_cfg_regs: configuration register file
// Eight write-only registers, written by index, reset to their defaults.
// ----------------------------------------------------------------------------
module dcs_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dcs_pkg::dcs_cfg_t               cfg
);

  dcs_pkg::dcs_cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (cfg_we) begin
      unique case (cfg_index)
        dcs_pkg::CFG_STANDBY_TICKS:    cfg_next.standby_ticks    = cfg_data[7:0];
        dcs_pkg::CFG_INIT_TICKS:       cfg_next.init_ticks       = cfg_data[7:0];
        dcs_pkg::CFG_WELD_TICKS:       cfg_next.weld_ticks       = cfg_data[7:0];
        dcs_pkg::CFG_PRECHARGE_TICKS:  cfg_next.precharge_ticks  = cfg_data[7:0];
        dcs_pkg::CFG_SETTLE_TICKS:     cfg_next.settle_ticks     = cfg_data[7:0];
        dcs_pkg::CFG_PRECHARGE_WINDOW: cfg_next.precharge_window = cfg_data[9:0];
        dcs_pkg::CFG_AC_POWER_CODE:    cfg_next.ac_power_code    = cfg_data[11:0];
        dcs_pkg::CFG_DC_POWER_CODE:    cfg_next.dc_power_code    = cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.standby_ticks    <= dcs_pkg::RST_STANDBY_TICKS;
      cfg.init_ticks       <= dcs_pkg::RST_INIT_TICKS;
      cfg.weld_ticks       <= dcs_pkg::RST_WELD_TICKS;
      cfg.precharge_ticks  <= dcs_pkg::RST_PRECHARGE_TICKS;
      cfg.settle_ticks     <= dcs_pkg::RST_SETTLE_TICKS;
      cfg.precharge_window <= dcs_pkg::RST_PRECHARGE_WINDOW;
      cfg.ac_power_code    <= dcs_pkg::RST_AC_POWER_CODE;
      cfg.dc_power_code    <= dcs_pkg::RST_DC_POWER_CODE;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// ===== rtl/core/dcs_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_step: next-state logic of one control tick
// Mode select, DC sequence walk and dwell counting, all combinational.
// ----------------------------------------------------------------------------
module dcs_step (
  input  dcs_pkg::dcs_cfg_t   cfg,
  input  dcs_pkg::dcs_in_t    tick,
  input  dcs_pkg::dcs_state_t cur,
  output dcs_pkg::dcs_state_t nxt,
  output logic [1:0]          charge_mode
);

  localparam logic [2:0] SEQ_STANDBY   = 3'd0;
  localparam logic [2:0] SEQ_INIT      = 3'd1;
  localparam logic [2:0] SEQ_WELD_RISE = 3'd2;
  localparam logic [2:0] SEQ_WELD_FALL = 3'd3;
  localparam logic [2:0] SEQ_PRECHARGE = 3'd4;
  localparam logic [2:0] SEQ_SETTLE    = 3'd5;
  localparam logic [2:0] SEQ_TRANSFER  = 3'd6;

  // Common output pattern; current cleared, request set
  function automatic dcs_pkg::dcs_state_t set_out(
    input dcs_pkg::dcs_state_t s,
    input logic [3:0]          ph,
    input logic [7:0]          eot,
    input logic [1:0]          st,
    input logic                rdy,
    input logic [11:0]         pwr
  );
    dcs_pkg::dcs_state_t r;
    r          = s;
    r.phase    = ph;
    r.current  = '0;
    r.end_time = eot;
    r.status   = st;
    r.request  = 1'b1;
    r.ready    = rdy;
    r.power    = pwr;
    return r;
  endfunction

  logic              enabled;
  logic              pilot_ac;
  logic              pilot_dc;
  logic [7:0]        dwell_inc;
  logic signed [11:0] volt_diff;
  logic              in_window;
  logic [7:0]        pre_count;

  assign enabled   = tick.plug_present && !tick.charge_disabled;
  assign pilot_ac  = (tick.pilot_mode == dcs_pkg::PILOT_PWM_A) ||
                     (tick.pilot_mode == dcs_pkg::PILOT_PWM_B);
  assign pilot_dc  = (tick.pilot_mode == dcs_pkg::PILOT_DC_A) ||
                     (tick.pilot_mode == dcs_pkg::PILOT_DC_B);
  assign dwell_inc = cur.dwell_count + 8'd1;
  assign volt_diff = $signed({2'b00, tick.battery_volts}) -
                     $signed({3'b000, tick.contactor_volts});
  assign in_window = volt_diff < $signed({2'b00, cfg.precharge_window});
  assign pre_count = in_window ? dwell_inc : cur.dwell_count;

  always_comb begin
    nxt         = cur;
    charge_mode = dcs_pkg::MODE_NONE;
    if (!tick.run_mode) begin
      if (enabled && pilot_ac) begin
        nxt = set_out(cur, dcs_pkg::PHASE_STANDBY, dcs_pkg::END_TIME_SET,
                      dcs_pkg::STATUS_READY_AC, 1'b1, cfg.ac_power_code);
        nxt.seq_state = SEQ_STANDBY;
        nxt.contactor = dcs_pkg::CONTACTOR_OPEN;
        charge_mode   = dcs_pkg::MODE_AC;
      end else if (enabled && pilot_dc) begin
        charge_mode = dcs_pkg::MODE_DC;
        unique case (cur.seq_state)
          SEQ_STANDBY: begin
            nxt = set_out(cur, dcs_pkg::PHASE_STANDBY, dcs_pkg::END_TIME_NONE,
                          dcs_pkg::STATUS_READY_DC, 1'b0, 12'd0);
            nxt.contactor   = dcs_pkg::CONTACTOR_OPEN;
            nxt.dwell_count = dwell_inc;
            if (dwell_inc > cfg.standby_ticks) begin
              nxt.seq_state   = SEQ_INIT;
              nxt.dwell_count = '0;
            end
          end
          SEQ_INIT: begin
            nxt = set_out(cur, dcs_pkg::PHASE_INIT, dcs_pkg::END_TIME_NONE,
                          dcs_pkg::STATUS_READY_DC, 1'b0, 12'd0);
            nxt.contactor   = dcs_pkg::CONTACTOR_OPEN;
            nxt.dwell_count = dwell_inc;
            if (dwell_inc > cfg.init_ticks) begin
              nxt.seq_state   = SEQ_WELD_RISE;
              nxt.dwell_count = '0;
            end
          end
          SEQ_WELD_RISE: begin
            nxt = set_out(cur, dcs_pkg::PHASE_WELD, dcs_pkg::END_TIME_SET,
                          dcs_pkg::STATUS_READY_DC, 1'b1, cfg.dc_power_code);
            nxt.contactor = dcs_pkg::CONTACTOR_OPEN;
            if (tick.contactor_volts != '0) begin
              nxt.seq_state = SEQ_WELD_FALL;
            end
          end
          SEQ_WELD_FALL: begin
            nxt = set_out(cur, dcs_pkg::PHASE_WELD, dcs_pkg::END_TIME_SET,
                          dcs_pkg::STATUS_READY_DC, 1'b1, cfg.dc_power_code);
            nxt.contactor = dcs_pkg::CONTACTOR_OPEN;
            // count only ticks with the charger side at zero volts
            if (tick.contactor_volts == '0) begin
              nxt.dwell_count = dwell_inc;
            end
            if (nxt.dwell_count > cfg.weld_ticks) begin
              nxt.seq_state   = SEQ_PRECHARGE;
              nxt.dwell_count = '0;
            end
          end
          SEQ_PRECHARGE: begin
            nxt = set_out(cur, dcs_pkg::PHASE_PRECHARGE, dcs_pkg::END_TIME_SET,
                          dcs_pkg::STATUS_READY_DC, 1'b1, cfg.dc_power_code);
            nxt.dwell_count = pre_count;
            // contactor left alone until the exit tick
            if (pre_count > cfg.precharge_ticks) begin
              nxt.seq_state   = SEQ_SETTLE;
              nxt.dwell_count = '0;
              nxt.contactor   = dcs_pkg::CONTACTOR_CLOSE;
            end
          end
          SEQ_SETTLE: begin
            nxt = set_out(cur, dcs_pkg::PHASE_TRANSFER, dcs_pkg::END_TIME_SET,
                          dcs_pkg::STATUS_READY_DC, 1'b1, cfg.dc_power_code);
            nxt.contactor   = dcs_pkg::CONTACTOR_CLOSE;
            nxt.dwell_count = dwell_inc;
            if (dwell_inc > cfg.settle_ticks) begin
              nxt.seq_state   = SEQ_TRANSFER;
              nxt.dwell_count = '0;
            end
          end
          SEQ_TRANSFER: begin
            nxt = set_out(cur, dcs_pkg::PHASE_TRANSFER, dcs_pkg::END_TIME_SET,
                          dcs_pkg::STATUS_READY_DC, 1'b1, cfg.dc_power_code);
            nxt.contactor = dcs_pkg::CONTACTOR_CLOSE;
            nxt.current   = tick.current_request;
          end
          default: ;  // unused code: hold everything
        endcase
      end else if (!enabled) begin
        // unplug or disable: off state, dwell count kept
        nxt.seq_state = SEQ_STANDBY;
        nxt.phase     = dcs_pkg::PHASE_STANDBY;
        nxt.contactor = dcs_pkg::CONTACTOR_OPEN;
        nxt.current   = '0;
        nxt.end_time  = dcs_pkg::END_TIME_NONE;
        nxt.status    = dcs_pkg::STATUS_NOT_READY;
        nxt.request   = 1'b0;
        nxt.ready     = 1'b0;
        nxt.power     = '0;
      end
    end
  end

endmodule

// ===== rtl/core/dc_charge_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dc_charge_sequencer: vehicle-side AC/DC charge control sequencer
// Takes one control tick per word and returns the charge command word.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one control tick per word (run mode, plug, disable, pilot,
//   contactor and battery volts, current request). m_axis returns exactly one
//   result word per tick, in order: charge mode, sequence state and the
//   command fields as they stand after that tick.
//   Flow: a tick moves from the input register into the result register, raising
//   m_axis_tvalid; one word is taken every cycle while m_axis_tready is high.
//   The sequence registers are updated once per tick, on that same move.
//   Back pressure: when m_axis_tready is low the result word holds, one more
//   tick may sit in the input register, and s_axis_tready then drops.
//   The configuration port writes the eight dwell, window and power
//   registers; write it only while no tick is in flight.
//   Reset (rst, synchronous) clears the sequence to standby with all commands
//   at zero, empties both pipeline registers and loads the default config.
// ----------------------------------------------------------------------------
module dc_charge_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  // config write port
  input  logic                             cfg_we,
  input  logic [dcs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dcs_pkg::CFG_DATA_W-1:0]   cfg_data,
  // tick words in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] run_mode, [1] plug_present, [2] charge_disabled, [5:3] pilot_mode,
  // [14:6] contactor_volts, [24:15] battery_volts, [34:25] current_request
  input  logic [dcs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // result words out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] charge_mode, [4:2] sequence_state, [8:5] target_phase,
  // [12:9] contactor_command, [22:13] current_command, [30:23] end_time_code,
  // [32:31] status_code, [33] charge_request, [34] ready_flag,
  // [46:35] power_code
  output logic [dcs_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  dcs_pkg::dcs_cfg_t   cfg;
  dcs_pkg::dcs_in_t    tick_d;
  dcs_pkg::dcs_in_t    tick;        // input register
  logic                tick_valid;
  dcs_pkg::dcs_state_t state;       // sequence registers
  dcs_pkg::dcs_state_t state_next;
  logic [1:0]          mode_next;
  logic                advance;     // tick moves into the result register
  logic [dcs_pkg::OUT_DATA_W-1:0] result_next;

  dcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dcs_step u_step (
    .cfg         (cfg),
    .tick        (tick),
    .cur         (state),
    .nxt         (state_next),
    .charge_mode (mode_next)
  );

  // unpack the tick word
  assign tick_d.run_mode        = s_axis_tdata[0];
  assign tick_d.plug_present    = s_axis_tdata[1];
  assign tick_d.charge_disabled = s_axis_tdata[2];
  assign tick_d.pilot_mode      = s_axis_tdata[5:3];
  assign tick_d.contactor_volts = s_axis_tdata[14:6];
  assign tick_d.battery_volts   = s_axis_tdata[24:15];
  assign tick_d.current_request = $signed(s_axis_tdata[34:25]);

  // the step result is committed only as it enters the result register
  assign advance       = tick_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !tick_valid || advance;

  assign result_next = {1'b0,
                        state_next.power,
                        state_next.ready,
                        state_next.request,
                        state_next.status,
                        state_next.end_time,
                        state_next.current,
                        state_next.contactor,
                        state_next.phase,
                        state_next.seq_state,
                        mode_next};

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (s_axis_tready) begin
      tick_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      tick <= tick_d;
    end
  end

  // sequence registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= result_next;
    end
  end

endmodule

// ===== tb/dcs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_checker: result checker for the DC charge sequencer
// Watches config writes and both stream channels and keeps its own copy of
// the sequencer state. It predicts one result per accepted tick and compares
// each result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module dcs_checker
  import dcs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [IN_DATA_W-1:0]   in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [OUT_DATA_W-1:0]  out_data,
  output int                     fail_count,
  output int                     pending,
  output int                     results_checked,
  output int                     ac_results,
  output int                     transfer_results
);

  typedef enum logic [2:0] {
    SEQ_STANDBY, SEQ_INIT, SEQ_WELD_RISE, SEQ_WELD_FALL,
    SEQ_PRECHARGE, SEQ_SETTLE, SEQ_TRANSFER
  } seq_e;

  typedef struct packed {
    logic [1:0] mode;
    dcs_state_t st;
  } dcs_result_t;

  dcs_cfg_t    regs;
  dcs_state_t  seq_model;
  dcs_result_t expected_q[$];

  function automatic dcs_state_t command(dcs_state_t s, logic [3:0] phase,
                                         logic [7:0] end_time, logic [1:0] status,
                                         logic ready, logic [11:0] power);
    dcs_state_t n;
    n          = s;
    n.phase    = phase;
    n.current  = '0;
    n.end_time = end_time;
    n.status   = status;
    n.request  = 1'b1;
    n.ready    = ready;
    n.power    = power;
    return n;
  endfunction

  function automatic dcs_state_t next_state(input dcs_state_t s, input dcs_cfg_t c,
                                            input dcs_in_t t, output logic [1:0] mode);
    dcs_state_t n;
    logic       enabled, pwm, dc;
    logic [7:0] dwell;
    int         gap;
    n       = s;
    mode    = MODE_NONE;
    enabled = t.plug_present && !t.charge_disabled;
    pwm     = (t.pilot_mode == PILOT_PWM_A) || (t.pilot_mode == PILOT_PWM_B);
    dc      = (t.pilot_mode == PILOT_DC_A) || (t.pilot_mode == PILOT_DC_B);
    gap     = int'(t.battery_volts) - int'(t.contactor_volts);
    if (t.run_mode) begin
      // run mode freezes everything
    end else if (enabled && pwm) begin
      n           = command(n, PHASE_STANDBY, END_TIME_SET, STATUS_READY_AC, 1'b1,
                            c.ac_power_code);
      n.seq_state = SEQ_STANDBY;
      n.contactor = CONTACTOR_OPEN;
      mode        = MODE_AC;
    end else if (enabled && dc) begin
      mode = MODE_DC;
      case (s.seq_state)
        SEQ_STANDBY, SEQ_INIT: begin
          n = command(n, (s.seq_state == SEQ_STANDBY) ? PHASE_STANDBY : PHASE_INIT,
                      END_TIME_NONE, STATUS_READY_DC, 1'b0, 12'd0);
          n.contactor   = CONTACTOR_OPEN;
          n.dwell_count = n.dwell_count + 8'd1;
          if (n.dwell_count > ((s.seq_state == SEQ_STANDBY) ? c.standby_ticks
                                                            : c.init_ticks)) begin
            n.seq_state   = s.seq_state + 3'd1;
            n.dwell_count = '0;
          end
        end
        SEQ_WELD_RISE: begin
          // dwell count untouched here
          n = command(n, PHASE_WELD, END_TIME_SET, STATUS_READY_DC, 1'b1, c.dc_power_code);
          n.contactor = CONTACTOR_OPEN;
          if (t.contactor_volts != '0) n.seq_state = SEQ_WELD_FALL;
        end
        SEQ_WELD_FALL: begin
          n = command(n, PHASE_WELD, END_TIME_SET, STATUS_READY_DC, 1'b1, c.dc_power_code);
          n.contactor = CONTACTOR_OPEN;
          if (t.contactor_volts == '0) n.dwell_count = n.dwell_count + 8'd1;
          if (n.dwell_count > c.weld_ticks) begin
            n.seq_state   = SEQ_PRECHARGE;
            n.dwell_count = '0;
          end
        end
        SEQ_PRECHARGE: begin
          // contactor only written on the exit tick
          n = command(n, PHASE_PRECHARGE, END_TIME_SET, STATUS_READY_DC, 1'b1,
                      c.dc_power_code);
          if (gap < int'(c.precharge_window)) n.dwell_count = n.dwell_count + 8'd1;
          if (n.dwell_count > c.precharge_ticks) begin
            n.seq_state   = SEQ_SETTLE;
            n.dwell_count = '0;
            n.contactor   = CONTACTOR_CLOSE;
          end
        end
        SEQ_SETTLE: begin
          n = command(n, PHASE_TRANSFER, END_TIME_SET, STATUS_READY_DC, 1'b1,
                      c.dc_power_code);
          n.contactor   = CONTACTOR_CLOSE;
          n.dwell_count = n.dwell_count + 8'd1;
          if (n.dwell_count > c.settle_ticks) begin
            n.seq_state   = SEQ_TRANSFER;
            n.dwell_count = '0;
          end
        end
        SEQ_TRANSFER: begin
          n = command(n, PHASE_TRANSFER, END_TIME_SET, STATUS_READY_DC, 1'b1,
                      c.dc_power_code);
          n.contactor = CONTACTOR_CLOSE;
          n.current   = t.current_request;
        end
        default: ;
      endcase
    end else if (!enabled) begin
      // off: everything cleared except the dwell count
      dwell         = s.dwell_count;
      n             = '0;
      n.dwell_count = dwell;
    end
    return n;
  endfunction

  task automatic check_field(input string name, input logic signed [12:0] want,
                             input logic signed [12:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    dcs_in_t     tick;
    dcs_result_t want, got;
    logic [1:0]  mode;
    if (rst) begin
      regs             = '{RST_STANDBY_TICKS, RST_INIT_TICKS, RST_WELD_TICKS,
                           RST_PRECHARGE_TICKS, RST_SETTLE_TICKS, RST_PRECHARGE_WINDOW,
                           RST_AC_POWER_CODE, RST_DC_POWER_CODE};
      seq_model        = '0;
      expected_q.delete();
      fail_count       = 0;
      results_checked  = 0;
      ac_results       = 0;
      transfer_results = 0;
      pending         <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STANDBY_TICKS:    regs.standby_ticks    = cfg_data[7:0];
          CFG_INIT_TICKS:       regs.init_ticks       = cfg_data[7:0];
          CFG_WELD_TICKS:       regs.weld_ticks       = cfg_data[7:0];
          CFG_PRECHARGE_TICKS:  regs.precharge_ticks  = cfg_data[7:0];
          CFG_SETTLE_TICKS:     regs.settle_ticks     = cfg_data[7:0];
          CFG_PRECHARGE_WINDOW: regs.precharge_window = cfg_data[9:0];
          CFG_AC_POWER_CODE:    regs.ac_power_code    = cfg_data[11:0];
          CFG_DC_POWER_CODE:    regs.dc_power_code    = cfg_data[11:0];
          default: ;
        endcase
      end

      // result side first: a word leaving now never belongs to a tick entering now
      if (out_valid && out_ready) begin
        got.mode              = out_data[1:0];
        got.st                = '0;
        got.st.seq_state      = out_data[4:2];
        got.st.phase          = out_data[8:5];
        got.st.contactor      = out_data[12:9];
        got.st.current        = out_data[22:13];
        got.st.end_time       = out_data[30:23];
        got.st.status         = out_data[32:31];
        got.st.request        = out_data[33];
        got.st.ready          = out_data[34];
        got.st.power          = out_data[46:35];
        if (expected_q.size() == 0) begin
          $display("%0t: result word %h with no tick pending, expected none", $time,
                   out_data);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("charge_mode", want.mode, got.mode);
          check_field("sequence_state", want.st.seq_state, got.st.seq_state);
          check_field("target_phase", want.st.phase, got.st.phase);
          check_field("contactor_command", want.st.contactor, got.st.contactor);
          check_field("current_command", want.st.current, got.st.current);
          check_field("end_time_code", want.st.end_time, got.st.end_time);
          check_field("status_code", want.st.status, got.st.status);
          check_field("charge_request", want.st.request, got.st.request);
          check_field("ready_flag", want.st.ready, got.st.ready);
          check_field("power_code", want.st.power, got.st.power);
          check_field("pad", 13'sd0, out_data[OUT_DATA_W-1:47]);
          results_checked++;
          if (want.mode == MODE_AC) ac_results++;
          if (want.mode == MODE_DC && want.st.seq_state == SEQ_TRANSFER) transfer_results++;
        end
      end

      if (in_valid && in_ready) begin
        tick.run_mode        = in_data[0];
        tick.plug_present    = in_data[1];
        tick.charge_disabled = in_data[2];
        tick.pilot_mode      = in_data[5:3];
        tick.contactor_volts = in_data[14:6];
        tick.battery_volts   = in_data[24:15];
        tick.current_request = in_data[34:25];
        seq_model = next_state(seq_model, regs, tick, mode);
        want.mode = mode;
        want.st   = seq_model;
        expected_q.push_back(want);
      end

      pending <= expected_q.size();
    end
  end

endmodule

// ===== tb/tb_dc_charge_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dc_charge_sequencer: regression bench for the DC charge sequencer
// Drives control ticks through the stream input under several register
// settings, with random idling on both channels; dcs_checker predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module tb_dc_charge_sequencer;
  import dcs_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int NUM_PHASES     = 7;
  localparam int PRESSURE_PHASE = 3;
  localparam int LONG_HOLD      = 80;   // receiver hold-off, cycles

  // pilot codes that are neither PWM nor 5%
  localparam logic [2:0] PILOT_NONE   = 3'd0;
  localparam logic [2:0] PILOT_RSVD_3 = 3'd3;
  localparam logic [2:0] PILOT_RSVD_6 = 3'd6;
  localparam logic [2:0] PILOT_RSVD_7 = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [0] run_mode, [1] plug_present, [2] charge_disabled, [5:3] pilot_mode,
  // [14:6] contactor_volts, [24:15] battery_volts, [34:25] current_request
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [1:0] charge_mode, [4:2] sequence_state, [8:5] target_phase,
  // [12:9] contactor_command, [22:13] current_command, [30:23] end_time_code,
  // [32:31] status_code, [33] charge_request, [34] ready_flag, [46:35] power_code
  logic [OUT_DATA_W-1:0]  m_axis_tdata;

  // stimulus control shared between the sender and receiver processes
  logic quiet          = 1'b0;  // last phase: no idling either side
  logic squeeze_req    = 1'b0;  // ask the receiver for one long hold-off
  logic squeeze_served = 1'b0;

  int fail_count, pending, results_checked, ac_results, transfer_results;
  int ticks_sent      = 0;
  int settings_loaded = 0;
  int cycle_count     = 0;

  dc_charge_sequencer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  dcs_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (s_axis_tvalid),
    .in_ready         (s_axis_tready),
    .in_data          (s_axis_tdata),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_data         (m_axis_tdata),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_checked  (results_checked),
    .ac_results       (ac_results),
    .transfer_results (transfer_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: several times the slowest legal run, longest idling included.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------
  function automatic logic [IN_DATA_W-1:0] tick_word(logic run, logic plug, logic off,
                                                    logic [2:0] pilot, logic [8:0] cv,
                                                    logic [9:0] bv, logic [9:0] ireq);
    logic [IN_DATA_W-1:0] w;
    w        = '0;
    w[0]     = run;
    w[1]     = plug;
    w[2]     = off;
    w[5:3]   = pilot;
    w[14:6]  = cv;
    w[24:15] = bv;
    w[34:25] = ireq;
    return w;
  endfunction

  // anything at all, contactor volts kept in range
  function automatic logic [IN_DATA_W-1:0] noise_word();
    return tick_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                     9'($urandom_range(0, 510)), 10'($urandom), 10'($urandom));
  endfunction

  // Well-formed DC tick. Mix of zero volts (weld fall counts), contactor near
  // battery (precharge window, both signs of the difference) and random volts.
  function automatic logic [IN_DATA_W-1:0] dc_word();
    logic [8:0] cv;
    logic [9:0] bv;
    int         flavor, near;
    flavor = $urandom_range(0, 9);
    bv     = 10'($urandom);
    cv     = 9'($urandom_range(0, 510));
    if (flavor <= 3) begin
      cv = '0;
    end else if (flavor <= 7) begin
      near = int'(cv) + $urandom_range(0, 50) - 10;
      bv   = (near < 0) ? 10'd0 : (near > 1023) ? 10'd1023 : 10'(near);
    end
    return tick_word(1'b0, 1'b1, 1'b0, $urandom_range(0, 1) ? PILOT_DC_A : PILOT_DC_B,
                     cv, bv, 10'($urandom));
  endfunction

  function automatic logic [IN_DATA_W-1:0] ac_word();
    return tick_word($urandom_range(0, 9) == 0, 1'b1, 1'b0,
                     $urandom_range(0, 1) ? PILOT_PWM_A : PILOT_PWM_B,
                     9'($urandom_range(0, 510)), 10'($urandom), 10'($urandom));
  endfunction

  // unplug or disable: sends the sequence back to standby
  function automatic logic [IN_DATA_W-1:0] unplug_word();
    logic plug;
    plug = 1'($urandom_range(0, 1));
    return tick_word(1'b0, plug, plug ? 1'b1 : 1'($urandom_range(0, 1)),
                     3'($urandom_range(0, 7)), 9'($urandom_range(0, 510)),
                     10'($urandom), 10'($urandom));
  endfunction

  // dwell thresholds: mostly short so sessions reach energy transfer
  function automatic logic [7:0] pick_ticks();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(13, 255))
                                       : 8'($urandom_range(0, 12));
  endfunction

  function automatic dcs_cfg_t random_settings();
    dcs_cfg_t c;
    c.standby_ticks    = pick_ticks();
    c.init_ticks       = pick_ticks();
    c.weld_ticks       = pick_ticks();
    c.precharge_ticks  = pick_ticks();
    c.settle_ticks     = pick_ticks();
    c.precharge_window = $urandom_range(0, 1) ? 10'($urandom_range(0, 60)) : 10'($urandom);
    c.ac_power_code    = 12'($urandom);
    c.dc_power_code    = 12'($urandom);
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers. Everything is driven with NBAs just after a rising edge;
  // ready is sampled at the falling edge so the handshake decision does not
  // race the block's own update at the rising edge.
  // --------------------------------------------------------------------------
  task automatic offer_tick(input logic [IN_DATA_W-1:0] w);
    logic took;
    if (!quiet && !(squeeze_req && !squeeze_served) && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do begin
      @(negedge clk);
      took = s_axis_tready;
      @(posedge clk);
    end while (!took);
    ticks_sent++;
  endtask

  // wait until every predicted word is back, plus the pipeline depth
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // writes all eight registers, one per cycle; only called with the block idle
  task automatic load_settings(input dcs_cfg_t c);
    logic [CFG_INDEX_W-1:0] idx;
    int                     i;
    for (i = 0; i < 8; i++) begin
      idx       = i[CFG_INDEX_W-1:0];
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      case (idx)
        CFG_STANDBY_TICKS:    cfg_data <= CFG_DATA_W'(c.standby_ticks);
        CFG_INIT_TICKS:       cfg_data <= CFG_DATA_W'(c.init_ticks);
        CFG_WELD_TICKS:       cfg_data <= CFG_DATA_W'(c.weld_ticks);
        CFG_PRECHARGE_TICKS:  cfg_data <= CFG_DATA_W'(c.precharge_ticks);
        CFG_SETTLE_TICKS:     cfg_data <= CFG_DATA_W'(c.settle_ticks);
        CFG_PRECHARGE_WINDOW: cfg_data <= CFG_DATA_W'(c.precharge_window);
        CFG_AC_POWER_CODE:    cfg_data <= CFG_DATA_W'(c.ac_power_code);
        default:              cfg_data <= CFG_DATA_W'(c.dc_power_code);
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Sessions: mostly plugged-in DC runs with random volts (the only way past
  // standby), some AC runs and pure noise; often an unplug between sessions.
  task automatic run_sessions(input int budget);
    int sent, len, kind, i;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(10, 90);
      for (i = 0; i < len && sent < budget; i++) begin
        if (kind <= 6)
          offer_tick(($urandom_range(0, 24) == 0) ? noise_word() : dc_word());
        else if (kind == 7)
          offer_tick(ac_word());
        else
          offer_tick(noise_word());
        sent++;
      end
      if (sent < budget && $urandom_range(0, 1) == 1) begin
        offer_tick(unplug_word());
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready runs and stall bursts, one long hold-off on
  // request (fills the block and backs up the input), steady ready at the end.
  // --------------------------------------------------------------------------
  initial begin
    wait (!rst);
    forever begin
      if (squeeze_req && !squeeze_served) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        squeeze_served <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    dcs_cfg_t walk_cfg, c;
    int       ph;
    walk_cfg = '{standby_ticks: 8'd0, init_ticks: 8'd0, weld_ticks: 8'd0,
                 precharge_ticks: 8'd0, settle_ticks: 8'd0, precharge_window: 10'd5,
                 ac_power_code: 12'hA5A, dc_power_code: 12'h5A5};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed, default register values.
    offer_tick(tick_word(1'b1, 1'b1, 1'b0, PILOT_DC_A, 9'd510, 10'd1023, 10'h1FF)); // run
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_PWM_A, 9'd0, 10'd0, 10'h200));     // AC
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_PWM_B, 9'd510, 10'd1023, 10'h1FF));
    offer_tick(tick_word(1'b1, 1'b0, 1'b1, PILOT_PWM_B, 9'd0, 10'd0, 10'h000)); // run wins
    // plugged and enabled, pilot neither PWM nor 5%: everything holds
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_NONE, 9'd1, 10'd1, 10'h001));
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_RSVD_3, 9'd2, 10'd2, 10'h002));
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_RSVD_6, 9'd3, 10'd3, 10'h003));
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_RSVD_7, 9'd4, 10'd4, 10'h004));
    offer_tick(tick_word(1'b0, 1'b0, 1'b0, PILOT_DC_A, 9'd0, 10'd0, 10'h000));  // unplug
    offer_tick(tick_word(1'b0, 1'b1, 1'b1, PILOT_PWM_A, 9'd0, 10'd0, 10'h000)); // disable
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_DC_A, 9'd0, 10'd0, 10'h000));  // standby
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_DC_B, 9'd0, 10'd0, 10'h000));
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_DC_A, 9'd0, 10'd0, 10'h000));
    // AC entry and off both leave the dwell count alone
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_PWM_A, 9'd0, 10'd0, 10'h000));
    offer_tick(tick_word(1'b0, 1'b1, 1'b1, PILOT_DC_B, 9'd0, 10'd0, 10'h000));
    drain();

    // Directed walk through the whole DC sequence with zero dwell thresholds.
    load_settings(walk_cfg);
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_DC_A, 9'd0, 10'd0, 10'h000));   // -> init
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_DC_B, 9'd0, 10'd0, 10'h000));   // -> weld
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_DC_A, 9'd0, 10'd0, 10'h000));   // waits
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_DC_A, 9'd510, 10'd0, 10'h000)); // rise seen
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_DC_B, 9'd300, 10'd0, 10'h000)); // no count
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_DC_A, 9'd0, 10'd0, 10'h000));   // precharge
    // outside the window, contactor stays open
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_DC_A, 9'd0, 10'd1023, 10'h000));
    // contactor above battery: negative difference counts, exit closes contactor
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_DC_B, 9'd200, 10'd100, 10'h000));
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_DC_A, 9'd200, 10'd200, 10'h000)); // settle
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_DC_A, 9'd200, 10'd200, 10'h200)); // -512
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_DC_B, 9'd200, 10'd200, 10'h1FF)); // 511
    offer_tick(tick_word(1'b1, 1'b1, 1'b0, PILOT_DC_A, 9'd200, 10'd200, 10'h3FF)); // hold
    offer_tick(tick_word(1'b0, 1'b1, 1'b0, PILOT_PWM_B, 9'd200, 10'd200, 10'h3FF)); // AC
    drain();

    // Random phases: all-zero and all-ones settings first, then random ones.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0)
        c = '0;
      else if (ph == 1)
        c = '1;
      else
        c = random_settings();
      if (ph == NUM_PHASES - 1) quiet <= 1'b1;
      load_settings(c);
      if (ph == PRESSURE_PHASE) squeeze_req <= 1'b1;
      run_sessions((ph == 1) ? 150 : 300);
      drain();
    end
    repeat (8) @(posedge clk);

    $display("Sent %0d control ticks under %0d register settings, zero and full scale included.",
             ticks_sent, settings_loaded);
    $display("Checked %0d result words: %0d in AC charge, %0d in DC energy transfer.",
             results_checked, ac_results, transfer_results);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
